/* sv/rxc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxc_pkg: shared types and constants of the record xor codec
// Request payloads, configuration bundle, register codes and key helpers.
// ----------------------------------------------------------------------------
package rxc_pkg;

	// record position counter width
	localparam int RECORD_SIZE_BITS = 16;
	// configuration address width (three 32-bit registers)
	localparam int CFG_ADDR_BITS = 4;

	// key cycle bytes
	localparam logic [7:0] KEY_BYTE_0 = 8'hfc;
	localparam logic [7:0] KEY_BYTE_1 = 8'hcf;
	localparam logic [7:0] KEY_BYTE_2 = 8'hab;
	// accumulator seed shift
	localparam int SEED_SHIFT = 9;

	// register indexes
	typedef enum logic [1:0] {
		REG_DIRECTION    = 2'd0,
		REG_RECORD_SIZE  = 2'd1,
		REG_CHECKSUM_KEY = 2'd2
	} reg_idx_t;

	// incoming request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_item_t;

	// outgoing result
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [31:0] checksum;
		logic        last_out;
	} out_item_t;

	// classified byte between front and back
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] cipher_byte;
		logic       is_last;
	} mid_item_t;

	// configuration register contents
	typedef struct packed {
		logic        direction;
		logic [15:0] record_size;
		logic [15:0] checksum_key;
	} cfg_t;

	// checksum key write, reseeds the accumulator
	typedef struct packed {
		logic        valid;
		logic [15:0] key;
	} key_load_t;

	// key byte for a phase of the three-byte cycle
	function automatic logic [7:0] key_byte(input logic [1:0] phase);
		logic [7:0] kb;
		case (phase)
			2'd1:    kb = KEY_BYTE_1;
			2'd2:    kb = KEY_BYTE_2;
			default: kb = KEY_BYTE_0;
		endcase
		return kb;
	endfunction

	// accumulator seed from the checksum key
	function automatic logic [31:0] acc_seed(input logic [15:0] key);
		return 32'(key) << SEED_SHIFT;
	endfunction

endpackage

/* sv/rxc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxc_regs: configuration register file
// APB-style slave holding direction, record size and checksum key.
// ----------------------------------------------------------------------------
module rxc_regs import rxc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output cfg_t                     cfg,
	output key_load_t                key_load
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_DIRECTION:    cfg_q.direction    <= pwdata[0];
				REG_RECORD_SIZE:  cfg_q.record_size  <= pwdata[15:0];
				REG_CHECKSUM_KEY: cfg_q.checksum_key <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_DIRECTION:    prdata = 32'(cfg_q.direction);
			REG_RECORD_SIZE:  prdata = 32'(cfg_q.record_size);
			REG_CHECKSUM_KEY: prdata = 32'(cfg_q.checksum_key);
			default:          prdata = '0;
		endcase
	end

	// key write reseeds the checksum
	assign key_load.valid = wr_en && (idx == REG_CHECKSUM_KEY);
	assign key_load.key   = pwdata[15:0];
	assign cfg            = cfg_q;

endmodule

/* sv/rxc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxc_front: request intake and key cycle
// Tracks key phase and record position, xors each byte with its key byte,
// picks the ciphertext byte and queues the result in a two-entry queue.
// ----------------------------------------------------------------------------
module rxc_front import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_data,
	output logic      head_valid,
	output mid_item_t head,
	input  logic      head_pop
);

	logic [1:0]                  phase_q;
	logic [RECORD_SIZE_BITS-1:0] pos_q;
	logic [1:0]                  phase_inc;
	logic [RECORD_SIZE_BITS-1:0] pos_inc;
	logic                        wrap;
	logic                        accept;
	logic [7:0]                  enc_byte;
	mid_item_t                   entry;

	mid_item_t q_mem [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;

	assign accept = push && !full;

	// byte classification
	assign enc_byte          = in_data.data_byte ^ key_byte(phase_q);
	assign entry.out_byte    = enc_byte;
	assign entry.cipher_byte = cfg.direction ? in_data.data_byte : enc_byte;
	assign entry.is_last     = in_data.is_last;

	// key cycle and record restart
	assign phase_inc = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
	assign pos_inc   = pos_q + 1'b1;
	assign wrap      = (cfg.record_size != '0) && (32'(pos_inc) == 32'(cfg.record_size));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (in_data.is_last || wrap) begin
				phase_q <= '0;
				pos_q   <= '0;
			end else begin
				phase_q <= phase_inc;
				pos_q   <= pos_inc;
			end
		end
	end

	// front-to-back queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= entry;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(head_pop);
		end
	end

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = q_mem[rd_ptr_q];

endmodule

/* sv/rxc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxc_back: checksum engine and result queue
// Packs ciphertext bytes into words, folds them into the keyed accumulator,
// mixes every fourth word in the cycle after its fold and queues the results.
// ----------------------------------------------------------------------------
module rxc_back import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  key_load_t key_load,
	input  logic      head_valid,
	input  mid_item_t head,
	output logic      head_pop,
	output logic      empty,
	output out_item_t out_data,
	input  logic      pop
);

	logic [23:0] partial_q, partial_d;
	logic [1:0]  lane_q, lane_d;
	logic [2:0]  widx_q, widx_d;
	logic [31:0] acc_q, acc_d;
	logic        mix_pend_q, mix_pend_d;
	logic        mix_sh5_q, mix_sh5_d;
	logic        held_q, held_d;

	logic [31:0] mix_sum;
	logic [31:0] mixed;
	logic [31:0] acc_base;
	logic [31:0] word;
	logic [31:0] folded;
	logic        go;
	logic        emit;
	logic        restart;
	out_item_t   res;

	out_item_t  oq_mem [2];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_count_q;
	logic       oq_full;
	logic       oq_pop;

	assign oq_full = (oq_count_q == 2'd2);
	assign oq_pop  = pop && !empty;
	assign go      = head_valid && (!oq_full || oq_pop);

	// deferred mix of a word whose index is a multiple of four
	assign mix_sum  = acc_q + 32'(cfg.checksum_key);
	assign mixed    = acc_q ^ (mix_sh5_q ? (mix_sum >> 5) : (mix_sum >> 1));
	assign acc_base = mix_pend_q ? mixed : acc_q;

	// word fold, only reached with no mix pending
	assign word   = {head.cipher_byte, partial_q};
	assign folded = (cfg.checksum_key[0] ^ widx_q[0]) ? (acc_q + word) : (acc_q ^ word);

	// per-byte sequencing
	always_comb begin
		acc_d      = acc_base;
		mix_pend_d = 1'b0;
		mix_sh5_d  = mix_sh5_q;
		held_d     = held_q;
		partial_d  = partial_q;
		lane_d     = lane_q;
		widx_d     = widx_q;
		head_pop   = 1'b0;
		emit       = 1'b0;
		restart    = 1'b0;
		res.out_byte = head.out_byte;
		res.checksum = '0;
		res.last_out = head.is_last;
		if (go) begin
			priority if (held_q) begin
				// last byte of a mixed word: checksum is ready now
				head_pop     = 1'b1;
				emit         = 1'b1;
				res.checksum = acc_base;
				restart      = 1'b1;
			end else if (lane_q == 2'd3) begin
				partial_d = '0;
				lane_d    = '0;
				widx_d    = widx_q + 3'd1;
				if (widx_q[1:0] == 2'd0) begin
					acc_d      = folded;
					mix_pend_d = 1'b1;
					mix_sh5_d  = widx_q[2];
					if (head.is_last) begin
						held_d = 1'b1;
					end else begin
						head_pop = 1'b1;
						emit     = 1'b1;
					end
				end else begin
					head_pop = 1'b1;
					emit     = 1'b1;
					if (head.is_last) begin
						res.checksum = folded;
						restart      = 1'b1;
					end else begin
						acc_d = folded;
					end
				end
			end else begin
				partial_d = partial_q | (24'(head.cipher_byte) << {lane_q, 3'b000});
				lane_d    = lane_q + 2'd1;
				head_pop  = 1'b1;
				emit      = 1'b1;
				if (head.is_last) begin
					res.checksum = acc_base;
					restart      = 1'b1;
				end
			end
		end
		// new message
		if (restart) begin
			acc_d      = acc_seed(cfg.checksum_key);
			partial_d  = '0;
			lane_d     = '0;
			widx_d     = '0;
			mix_pend_d = 1'b0;
			held_d     = 1'b0;
		end
		// key write reseeds at once
		if (key_load.valid) begin
			acc_d      = acc_seed(key_load.key);
			mix_pend_d = 1'b0;
		end
	end

	// checksum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			lane_q     <= '0;
			widx_q     <= '0;
			acc_q      <= '0;
			mix_pend_q <= 1'b0;
			mix_sh5_q  <= 1'b0;
			held_q     <= 1'b0;
		end else begin
			partial_q  <= partial_d;
			lane_q     <= lane_d;
			widx_q     <= widx_d;
			acc_q      <= acc_d;
			mix_pend_q <= mix_pend_d;
			mix_sh5_q  <= mix_sh5_d;
			held_q     <= held_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			oq_mem[oq_wr_q] <= res;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= 1'b0;
			oq_rd_q    <= 1'b0;
			oq_count_q <= '0;
		end else begin
			if (emit) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_count_q <= oq_count_q + 2'(emit) - 2'(oq_pop);
		end
	end

	assign empty    = (oq_count_q == 2'd0);
	assign out_data = oq_mem[oq_rd_q];

endmodule

/* sv/record_xor_codec_with_keyed_checksum_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_xor_codec_with_keyed_checksum_core: record xor codec, top level
// Keyed xor byte codec with a 32-bit keyed checksum over the ciphertext.
// ----------------------------------------------------------------------------
// path: a request is registered in the front queue, then its result in the result queue;
//   a message's last byte that closes a word needing a mix waits for that mix first
// throughput: one byte per cycle while results are popped; the mix of every fourth word
//   runs in the cycle after the fold and costs a stall only at the end of such a message
// reset: arst_n clears registers, key state, checksum and both queues
module record_xor_codec_with_keyed_checksum_core import rxc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  in_item_t                 in_data,
	output logic                     empty,
	input  logic                     pop,
	output out_item_t                out_data,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	cfg_t      cfg;
	key_load_t key_load;
	logic      head_valid;
	mid_item_t head;
	logic      head_pop;

	// configuration registers
	rxc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.key_load (key_load)
	);

	// intake and key cycle
	rxc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.push       (push),
		.full       (full),
		.in_data    (in_data),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	// checksum and results
	rxc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.key_load   (key_load),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.out_data   (out_data),
		.pop        (pop)
	);

endmodule

/* sv/rxc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxc_checker: port-level checks of the record xor codec
// Watches the queue and register ports of the top level.
// ----------------------------------------------------------------------------
module rxc_checker import rxc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     empty,
	input logic                     pop,
	input out_item_t                out_data,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [CFG_ADDR_BITS-1:0] paddr,
	input logic [31:0]              pwdata,
	input logic [31:0]              prdata,
	input logic                     pready
);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	// a waiting result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
	else $error("waiting result changed or vanished");

	// checksum only on the final byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.last_out) |-> (out_data.checksum == 32'd0))
	else $error("checksum nonzero on a non-final result");

	// direction register reads back what was written
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[3:2] == REG_DIRECTION) ##1
		(!cfg_wr && paddr[3:2] == REG_DIRECTION)
		|-> (prdata[0] == $past(pwdata[0])))
	else $error("direction register read back mismatch");

endmodule

bind record_xor_codec_with_keyed_checksum_core rxc_checker u_rxc_checker (.*);

/* bench/record_xor_codec_with_keyed_checksum_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_xor_codec_with_keyed_checksum_core_tb: self-checking bench of the codec
// Pushes byte requests through the input queue and pops results at random rates.
// A bit-accurate predictor of the key cycle, record restart and keyed checksum
// builds the expected results. The registers are walked through several settings.
// ----------------------------------------------------------------------------
module record_xor_codec_with_keyed_checksum_core_tb;
	import rxc_pkg::*;

	localparam int          CLK_HALF       = 6;
	localparam int          RESET_CYCLES   = 11;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int          MAX_REPORTS    = 10;
	localparam int          PHASES         = 12;
	localparam int          PHASE_REQUESTS = 112;
	localparam int          HOLD_PHASE     = 5;
	localparam int          HOLD_CYCLES    = 200;
	localparam int          SETTLE_CYCLES  = 4;
	localparam logic [1:0]  UNUSED_REG_IDX = 2'd3;

	// expected results of the codec, kept in request order
	class codec_prediction;
		logic [7:0]                  key_cycle [3];
		logic                        cfg_direction;
		logic [15:0]                 cfg_record_size;
		logic [15:0]                 cfg_key;
		logic [1:0]                  key_phase;
		logic [RECORD_SIZE_BITS-1:0] record_pos;
		logic [23:0]                 partial_word;
		logic [1:0]                  byte_lane;
		logic [2:0]                  word_index;
		logic [31:0]                 checksum_acc;
		out_item_t                   pending_results[$];
		int                          mismatches;

		function new();
			key_cycle = '{KEY_BYTE_0, KEY_BYTE_1, KEY_BYTE_2};
			cfg_direction = 1'b0;
			cfg_record_size = '0;
			cfg_key = '0;
			mismatches = 0;
			start_message();
		endfunction

		function void start_message();
			key_phase = '0;
			record_pos = '0;
			partial_word = '0;
			byte_lane = '0;
			word_index = '0;
			checksum_acc = {16'd0, cfg_key} << SEED_SHIFT;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_DIRECTION: begin
					cfg_direction = value[0];
				end
				REG_RECORD_SIZE: begin
					cfg_record_size = value[15:0];
				end
				REG_CHECKSUM_KEY: begin
					// new key reseeds the running checksum at once
					cfg_key = value[15:0];
					checksum_acc = {16'd0, cfg_key} << SEED_SHIFT;
				end
				default: begin
				end
			endcase
		endfunction

		function void fold_word(logic [31:0] word);
			int mix_shift;
			// parity of key plus word index picks xor or add
			if (cfg_key[0] == word_index[0])
				checksum_acc ^= word;
			else
				checksum_acc += word;
			// every fourth word gets mixed
			if (word_index[1:0] == 2'd0) begin
				mix_shift = int'(word_index) + 1;
				checksum_acc ^= (checksum_acc + {16'd0, cfg_key}) >> mix_shift;
			end
			word_index = word_index + 3'd1;
		endfunction

		function void note_byte(in_item_t req);
			logic [1:0] phase;
			logic [7:0] coded;
			logic [7:0] cipher;
			out_item_t  result;
			phase = (key_phase < 2'd3) ? key_phase : 2'd0;
			coded = req.data_byte ^ key_cycle[phase];
			cipher = cfg_direction ? req.data_byte : coded;
			// pack ciphertext little-endian, fold on the fourth byte
			if (byte_lane == 2'd3) begin
				fold_word({cipher, partial_word});
				partial_word = '0;
				byte_lane = '0;
			end else begin
				partial_word |= 24'(cipher) << (8 * byte_lane);
				byte_lane = byte_lane + 2'd1;
			end
			// key cycle advances, restarts at the record boundary
			key_phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
			record_pos = record_pos + 1'b1;
			if (cfg_record_size != 16'd0 && record_pos == cfg_record_size) begin
				key_phase = '0;
				record_pos = '0;
			end
			result.out_byte = coded;
			result.checksum = req.is_last ? checksum_acc : 32'd0;
			result.last_out = req.is_last;
			if (req.is_last)
				start_message();
			pending_results.push_back(result);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				flag($sformatf("result with nothing pending: byte %h sum %h last %b",
					got.out_byte, got.checksum, got.last_out));
				return;
			end
			want = pending_results.pop_front();
			if (got.out_byte !== want.out_byte || got.checksum !== want.checksum ||
					got.last_out !== want.last_out)
				flag($sformatf("expected byte %h sum %h last %b, got byte %h sum %h last %b",
					want.out_byte, want.checksum, want.last_out,
					got.out_byte, got.checksum, got.last_out));
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	in_item_t                 in_data;
	logic                     empty;
	logic                     pop;
	out_item_t                out_data;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	codec_prediction prediction;
	int              tx_idle_max;
	int              rx_idle_max;
	int              rx_hold_req;
	int              msg_left;
	int unsigned     cycle_count = 0;

	record_xor_codec_with_keyed_checksum_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_data (in_data),
		.empty   (empty),
		.pop     (pop),
		.out_data(out_data),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("record_xor_codec_with_keyed_checksum_core test failed");
			$finish;
		end
	end

	// one byte request, after a random gap
	task automatic send_byte(input logic [7:0] data, input logic last);
		int       gap;
		in_item_t req;
		gap = $urandom_range(0, tx_idle_max);
		req.data_byte = data;
		req.is_last = last;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
		prediction.note_byte(req);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// messages of random length with random content, may run across phases
	task automatic send_stream(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			if (msg_left == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					msg_left = $urandom_range(1, 12);
				else if (pick < 9)
					msg_left = $urandom_range(13, 40);
				else
					msg_left = $urandom_range(41, 100);
			end
			msg_left--;
			send_byte(8'($urandom), msg_left == 0);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		prediction.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CFG_ADDR_BITS'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			prediction.flag($sformatf("register %0d read %h, expected %h", idx, prdata, want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// all three registers, upper bits filled with noise, then read back
	task automatic configure(input logic dir, input logic [15:0] rec_size,
			input logic [15:0] key);
		write_reg(REG_DIRECTION, (32'($urandom) & ~32'd1) | 32'(dir));
		write_reg(REG_RECORD_SIZE, {16'($urandom), rec_size});
		write_reg(REG_CHECKSUM_KEY, {16'($urandom), key});
		read_check(REG_DIRECTION, 32'(dir));
		read_check(REG_RECORD_SIZE, 32'(rec_size));
		read_check(REG_CHECKSUM_KEY, 32'(key));
	endtask

	task automatic wait_idle();
		while (prediction.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// result side
	initial begin : result_sink
		int stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req > 0) begin
				stall = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				stall = $urandom_range(0, rx_idle_max);
			end
			repeat (stall) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			prediction.check_result(out_data);
		end
	end

	// stimulus
	initial begin : stimulus
		logic        dir;
		logic [15:0] rec_size;
		logic [15:0] key;
		prediction = new();
		arst_n = 1'b0;
		push = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_max = 7;
		rx_idle_max = 7;
		rx_hold_req = 0;
		msg_left = 0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values
		read_check(REG_DIRECTION, 32'd0);
		read_check(REG_RECORD_SIZE, 32'd0);
		read_check(REG_CHECKSUM_KEY, 32'd0);

		// encode, three-byte records, all-ones key, stray write to an unused index;
		// five bytes leave a trailing partial word out of the checksum
		write_reg(UNUSED_REG_IDX, 32'hffff_ffff);
		configure(1'b0, 16'd3, 16'hffff);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7f, 1'b1);
		stop_sending();
		wait_idle();

		// decode, no restart, zero key; five words reach both mix shifts
		configure(1'b1, 16'd0, 16'd0);
		for (int i = 0; i < 20; i++)
			send_byte((i == 0) ? 8'hff : 8'($urandom), i == 19);
		stop_sending();
		wait_idle();

		// random phases, each with fresh settings; messages may stay open across them
		for (int phase = 0; phase < PHASES; phase++) begin
			dir = 1'($urandom);
			case ($urandom_range(0, 4))
				0: rec_size = 16'd0;
				1: rec_size = 16'($urandom_range(1, 4));
				2: rec_size = 16'($urandom_range(5, 40));
				3: rec_size = 16'($urandom_range(41, 400));
				default: rec_size = 16'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0: key = 16'd0;
				1: key = 16'hffff;
				default: key = 16'($urandom);
			endcase
			if (phase == 0) begin
				rec_size = 16'hffff;
				key = 16'hffff;
			end else if (phase == 1) begin
				rec_size = 16'd1;
				key = 16'd0;
			end
			configure(dir, rec_size, key);

			// idle patterns per phase, including stretches with no gaps
			case (phase % 4)
				0: begin
					tx_idle_max = 7;
					rx_idle_max = 7;
				end
				1: begin
					tx_idle_max = 0;
					rx_idle_max = 0;
				end
				2: begin
					tx_idle_max = 0;
					rx_idle_max = 7;
				end
				default: begin
					tx_idle_max = 7;
					rx_idle_max = 0;
				end
			endcase
			// long hold-off on the result side while requests keep coming
			if (phase == HOLD_PHASE) begin
				tx_idle_max = 0;
				rx_hold_req = HOLD_CYCLES;
			end

			send_stream(PHASE_REQUESTS);
			stop_sending();
			wait_idle();
		end

		if (prediction.mismatches == 0 && prediction.pending_results.size() == 0)
			$display("record_xor_codec_with_keyed_checksum_core test passed");
		else
			$display("record_xor_codec_with_keyed_checksum_core test failed");
		$finish;
	end

endmodule
